[sv/clws_pkg.sv]
// Package with the types, codes and address helpers of the character LCD write sequencer.
package clws_pkg;

  localparam int RunDepth = 10;
  localparam int RunIdxW  = 4;
  localparam int GlyphRows = 8;

  typedef enum logic [1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_LOAD_GLYPH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_COLUMNS_PER_LINE = 2'd0,
    REG_LINES_IN_USE     = 2'd1,
    REG_WRAP_ENABLE      = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_idx_t;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] BASE_LINE1    = 8'h00;
  localparam logic [7:0] BASE_LINE2    = 8'h40;
  localparam logic [7:0] BASE_LINE3    = 8'h14;
  localparam logic [7:0] BASE_LINE4    = 8'h54;

  localparam logic [5:0] RST_COLUMNS = 6'd20;
  localparam logic [2:0] RST_LINES   = 3'd4;
  localparam logic       RST_WRAP    = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [2:0]  target_line;
    logic [5:0]  target_column;
    logic [3:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } in_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_byte;
    logic       last_of_run;
  } out_t;

  function automatic logic [7:0] line_base(input logic [2:0] line);
    logic [7:0] base;
    case (line)
      3'd2:    base = BASE_LINE2;
      3'd3:    base = BASE_LINE3;
      3'd4:    base = BASE_LINE4;
      default: base = BASE_LINE1;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] addr_cmd(input logic [2:0] line, input logic [5:0] column);
    logic [7:0] pos;
    pos = line_base(line) + {2'b00, column} - 8'd1;
    return pos | CMD_SET_DDRAM;
  endfunction

  function automatic logic [2:0] clamp_line(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > 3'd4) begin
      r = 3'd4;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[sv/char_lcd_write_sequencer.sv]
// Top level of the character LCD write sequencer: cursor tracking, run buffer and output register.
//
// Each accepted request is decoded into a run of bus writes that is registered into a
// ten-entry run buffer, and the cursor is updated at the same edge. The run buffer hands one
// write per cycle to the output register while the output is not stalled, so the request rate
// is set by the length of its run: a character write, a set cursor or a clear is a run of one
// write, a character write that changes line with wrap enabled a run of two, and a glyph load
// a run of ten. A new request is taken in the cycle in which the last write of the previous
// run moves to the output register, so single-write requests stream at one per cycle while
// the output is not stalled. A glyph slot above 7 produces no writes. The configuration port
// is always ready and should only be written while no run is pending.
module char_lcd_write_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clws_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clws_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  clws_pkg::reg_idx_t  cfg_index,
  input  logic [5:0]          cfg_data
);

  logic [5:0] columns_r;
  logic [2:0] lines_r;
  logic       wrap_r;
  logic [2:0] cur_line_r, cur_line_nxt;
  logic [5:0] cur_col_r, cur_col_nxt;

  clws_pkg::out_t ent_r [clws_pkg::RunDepth];
  clws_pkg::out_t ent_nxt [clws_pkg::RunDepth];
  logic [clws_pkg::RunIdxW-1:0] cnt_r, cnt_nxt;
  logic [clws_pkg::RunIdxW-1:0] idx_r;

  logic           out_valid_r;
  clws_pkg::out_t out_data_r;

  logic in_fire;
  logic move;

  logic [2:0] lines_eff;
  logic [2:0] tl_eff;
  logic       newline;

  assign cfg_ready = 1'b1;
  assign move      = (idx_r != cnt_r) && (!out_valid_r || out_ready);
  assign in_ready  = (idx_r == cnt_r) || (move && ((idx_r + 1'b1) == cnt_r));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    lines_eff    = clws_pkg::clamp_line(lines_r);
    tl_eff       = clws_pkg::clamp_line(in_data.target_line);
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    newline      = 1'b0;
    cnt_nxt      = '0;
    for (int i = 0; i < clws_pkg::RunDepth; i++) begin
      ent_nxt[i] = '{register_select: 1'b0, bus_byte: 8'h00, last_of_run: 1'b0};
    end
    case (clws_pkg::op_t'(in_data.operation))
      clws_pkg::OP_WRITE_CHAR: begin
        ent_nxt[0].register_select = 1'b1;
        ent_nxt[0].bus_byte        = in_data.char_code;
        if (({1'b0, cur_col_r} + 7'd1) <= {1'b0, columns_r}) begin
          cur_col_nxt = cur_col_r + 6'd1;
        end else if (({1'b0, cur_line_r} + 4'd1) <= {1'b0, lines_eff}) begin
          cur_line_nxt = cur_line_r + 3'd1;
          cur_col_nxt  = 6'd1;
          newline      = 1'b1;
        end else begin
          cur_line_nxt = 3'd1;
          cur_col_nxt  = 6'd1;
          newline      = 1'b1;
        end
        if (newline && wrap_r) begin
          ent_nxt[1].bus_byte    = clws_pkg::addr_cmd(cur_line_nxt, cur_col_nxt);
          ent_nxt[1].last_of_run = 1'b1;
          cnt_nxt                = 4'd2;
        end else begin
          ent_nxt[0].last_of_run = 1'b1;
          cnt_nxt                = 4'd1;
        end
      end
      clws_pkg::OP_SET_CURSOR: begin
        cur_line_nxt           = tl_eff;
        cur_col_nxt            = in_data.target_column;
        ent_nxt[0].bus_byte    = clws_pkg::addr_cmd(tl_eff, in_data.target_column);
        ent_nxt[0].last_of_run = 1'b1;
        cnt_nxt                = 4'd1;
      end
      clws_pkg::OP_CLEAR: begin
        cur_line_nxt           = 3'd1;
        cur_col_nxt            = 6'd1;
        ent_nxt[0].bus_byte    = clws_pkg::CMD_CLEAR;
        ent_nxt[0].last_of_run = 1'b1;
        cnt_nxt                = 4'd1;
      end
      clws_pkg::OP_LOAD_GLYPH: begin
        if (!in_data.glyph_slot[3]) begin
          ent_nxt[0].bus_byte = clws_pkg::CMD_SET_CGRAM | {2'b00, in_data.glyph_slot[2:0], 3'b000};
          for (int r = 0; r < clws_pkg::GlyphRows; r++) begin
            ent_nxt[r + 1].register_select = 1'b1;
            ent_nxt[r + 1].bus_byte        = in_data.glyph_rows[8*r +: 8];
          end
          ent_nxt[clws_pkg::RunDepth-1].bus_byte    = clws_pkg::addr_cmd(cur_line_r, cur_col_r);
          ent_nxt[clws_pkg::RunDepth-1].last_of_run = 1'b1;
          cnt_nxt = clws_pkg::RunIdxW'(clws_pkg::RunDepth);
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r  <= clws_pkg::RST_COLUMNS;
      lines_r    <= clws_pkg::RST_LINES;
      wrap_r     <= clws_pkg::RST_WRAP;
      cur_line_r <= 3'd1;
      cur_col_r  <= 6'd1;
      cnt_r      <= '0;
      idx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          clws_pkg::REG_COLUMNS_PER_LINE: columns_r <= cfg_data;
          clws_pkg::REG_LINES_IN_USE:     lines_r   <= cfg_data[2:0];
          clws_pkg::REG_WRAP_ENABLE:      wrap_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        cur_line_r <= cur_line_nxt;
        cur_col_r  <= cur_col_nxt;
        cnt_r      <= cnt_nxt;
        idx_r      <= '0;
      end else if (move) begin
        idx_r <= idx_r + 1'b1;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < clws_pkg::RunDepth; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
    if (move) begin
      out_data_r <= ent_r[idx_r];
    end
  end

endmodule

[sv/clws_checker.sv]
// Port-level checker for the character LCD write sequencer, bound to its top level.
module clws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input clws_pkg::in_t      in_data,
  input logic               out_valid,
  input logic               out_ready,
  input clws_pkg::out_t     out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input clws_pkg::reg_idx_t cfg_index,
  input logic [5:0]         cfg_data
);

  logic produces_run;
  assign produces_run = (in_data.operation != clws_pkg::OP_LOAD_GLYPH) || !in_data.glyph_slot[3];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result valid dropped before its transfer.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Result payload changed while stalled.");

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && produces_run |-> ##2 out_valid)
    else $error("Accepted request did not present a bus write in time.");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("Run of bus writes broke off before its last write.");

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (.*);
